// ===== design/pdcm_pkg.sv =====
// Package for the duty-cycle meter: payload types, microcode and sequencer constants.
package pdcm_pkg;

    localparam int TIME_BITS = 16;
    localparam int PCT_BITS  = 7;
    localparam int PROD_BITS = TIME_BITS + PCT_BITS;
    localparam int DIV_BITS  = PCT_BITS;
    localparam int CNT_BITS  = $clog2(DIV_BITS + 1);
    localparam logic [PCT_BITS-1:0] PCT_FULL = PCT_BITS'(100);

    typedef struct packed {
        logic        rising;
        logic [15:0] capture_time;
    } edge_item_t;

    typedef struct packed {
        logic [6:0]  duty_percent;
        logic [15:0] period_ticks;
        logic [15:0] high_ticks;
        logic [15:0] edge_count;
    } result_item_t;

    // Datapath operations
    localparam logic [3:0] OP_NONE     = 4'd0;
    localparam logic [3:0] OP_LOAD     = 4'd1;
    localparam logic [3:0] OP_RISE     = 4'd2;
    localparam logic [3:0] OP_FALL     = 4'd3;
    localparam logic [3:0] OP_MUL      = 4'd4;
    localparam logic [3:0] OP_SAT      = 4'd5;
    localparam logic [3:0] OP_DIV_INIT = 4'd6;
    localparam logic [3:0] OP_DIV_STEP = 4'd7;
    localparam logic [3:0] OP_TAKE_Q   = 4'd8;
    localparam logic [3:0] OP_EMIT     = 4'd9;

    // Jump conditions
    localparam logic [3:0] C_NEVER       = 4'd0;
    localparam logic [3:0] C_ALWAYS      = 4'd1;
    localparam logic [3:0] C_NO_ITEM     = 4'd2;
    localparam logic [3:0] C_RISING      = 4'd3;
    localparam logic [3:0] C_NO_OPEN     = 4'd4;
    localparam logic [3:0] C_ZERO_PERIOD = 4'd5;
    localparam logic [3:0] C_HIGH_GE     = 4'd6;
    localparam logic [3:0] C_LOOP        = 4'd7;
    localparam logic [3:0] C_SAME        = 4'd8;
    localparam logic [3:0] C_OUT_BUSY    = 4'd9;

    localparam int STEP_BITS = 4;

    // Program steps
    localparam logic [STEP_BITS-1:0] S_IDLE     = 4'd0;
    localparam logic [STEP_BITS-1:0] S_RISE     = 4'd1;
    localparam logic [STEP_BITS-1:0] S_FALL     = 4'd2;
    localparam logic [STEP_BITS-1:0] S_MUL      = 4'd3;
    localparam logic [STEP_BITS-1:0] S_SAT      = 4'd4;
    localparam logic [STEP_BITS-1:0] S_DIV_INIT = 4'd5;
    localparam logic [STEP_BITS-1:0] S_DIV_STEP = 4'd6;
    localparam logic [STEP_BITS-1:0] S_TAKE_Q   = 4'd7;
    localparam logic [STEP_BITS-1:0] S_COMPARE  = 4'd8;
    localparam logic [STEP_BITS-1:0] S_EMIT     = 4'd9;
    localparam logic [STEP_BITS-1:0] S_DONE     = 4'd10;

    typedef struct packed {
        logic [3:0]           op;
        logic [3:0]           cond;
        logic [STEP_BITS-1:0] target;
    } ctrl_t;

    typedef struct packed {
        logic no_item;
        logic rising;
        logic no_open;
        logic zero_period;
        logic high_ge;
        logic loop;
        logic same;
        logic out_busy;
    } flags_t;

    // Control store: if cond holds, jump to target, else fall through
    function automatic ctrl_t rom_word(input logic [STEP_BITS-1:0] step);
        ctrl_t w;
        case (step)
            S_IDLE:     w = '{OP_LOAD,     C_NO_ITEM,     S_IDLE};
            S_RISE:     w = '{OP_RISE,     C_RISING,      S_IDLE};
            S_FALL:     w = '{OP_FALL,     C_NO_OPEN,     S_IDLE};
            S_MUL:      w = '{OP_MUL,      C_ZERO_PERIOD, S_IDLE};
            S_SAT:      w = '{OP_SAT,      C_HIGH_GE,     S_COMPARE};
            S_DIV_INIT: w = '{OP_DIV_INIT, C_NEVER,       S_IDLE};
            S_DIV_STEP: w = '{OP_DIV_STEP, C_LOOP,        S_DIV_STEP};
            S_TAKE_Q:   w = '{OP_TAKE_Q,   C_NEVER,       S_IDLE};
            S_COMPARE:  w = '{OP_NONE,     C_SAME,        S_IDLE};
            S_EMIT:     w = '{OP_EMIT,     C_OUT_BUSY,    S_EMIT};
            S_DONE:     w = '{OP_NONE,     C_ALWAYS,      S_IDLE};
            default:    w = '{OP_NONE,     C_ALWAYS,      S_IDLE};
        endcase
        return w;
    endfunction

endpackage

// ===== design/pdcm_seq.sv =====
// Microcode sequencer: step counter, control store and conditional jumps.
module pdcm_seq
    import pdcm_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  flags_t               flags,
    output ctrl_t                ctrl,
    output logic [STEP_BITS-1:0] step
);

    logic [STEP_BITS-1:0] step_reg;
    logic [STEP_BITS-1:0] step_next;
    logic                 take;

    assign ctrl = rom_word(step_reg);
    assign step = step_reg;

    always_comb
    begin
        case (ctrl.cond)
            C_NEVER:       take = 1'b0;
            C_ALWAYS:      take = 1'b1;
            C_NO_ITEM:     take = flags.no_item;
            C_RISING:      take = flags.rising;
            C_NO_OPEN:     take = flags.no_open;
            C_ZERO_PERIOD: take = flags.zero_period;
            C_HIGH_GE:     take = flags.high_ge;
            C_LOOP:        take = flags.loop;
            C_SAME:        take = flags.same;
            C_OUT_BUSY:    take = flags.out_busy;
            default:       take = 1'b1;
        endcase
        step_next = take ? ctrl.target : step_reg + STEP_BITS'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg <= S_IDLE;
        end
        else
        begin
            step_reg <= step_next;
        end
    end

endmodule

// ===== design/pwm_duty_cycle_meter_top.sv =====
// Top level of the duty-cycle meter: handshakes, datapath and sequencer instance.
//
// Usage
//   Edge channel: one request per captured signal edge (direction and timer
//   value). Result channel: one request each time the duty percentage
//   changes, carrying duty, period, high time and the edge count.
//   Both channels use valid/stall; a request moves when valid is high and
//   stall is low.
// Timing
//   Edges are handled one at a time by a microcoded sequencer. edge_stall is
//   high while an edge is being worked on.
//   A rising edge stores its time; an opening falling edge stores its time.
//   A closing falling edge stops if the period is zero, skips the divide if
//   the duty saturates, and else runs the 7-step restoring divide.
//   A result appears in the output register in the cycle after the emit step.
// Stalls
//   The output register holds a result while result_stall is high; the
//   sequencer waits at its emit step only if a second result is ready
//   before the first has gone. Edges that give no result are not held up.
// Reset
//   rst_n clears the stored rise and fall times, the open measurement, the
//   last duty, the edge counter and the output valid.
module pwm_duty_cycle_meter_top
    import pdcm_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         edge_valid,
    output logic         edge_stall,
    input  edge_item_t   edge_item,
    output logic         result_valid,
    input  logic         result_stall,
    output result_item_t result_item
);

    ctrl_t                ctrl;
    flags_t               flags;
    logic [STEP_BITS-1:0] step;

    logic edge_take;
    logic out_free;

    // item latched at acceptance
    logic                 rising_reg,  rising_next;
    logic [TIME_BITS-1:0] now_reg,     now_next;
    logic [15:0]          edges_reg,   edges_next;

    // measurement state
    logic [TIME_BITS-1:0] rise_reg,    rise_next;
    logic [TIME_BITS-1:0] ff_reg,      ff_next;
    logic                 have_reg,    have_next;
    logic [PCT_BITS-1:0]  last_reg,    last_next;

    // working registers
    logic [TIME_BITS-1:0] period_reg,  period_next;
    logic [TIME_BITS-1:0] high_reg,    high_next;
    logic [PROD_BITS-1:0] prod_reg,    prod_next;
    logic [TIME_BITS-1:0] rem_reg,     rem_next;
    logic [DIV_BITS-1:0]  dq_reg,      dq_next;
    logic [CNT_BITS-1:0]  cnt_reg,     cnt_next;
    logic [PCT_BITS-1:0]  pct_reg,     pct_next;

    // output register
    result_item_t         out_reg,     out_next;
    logic                 out_vld_reg, out_vld_next;

    logic [TIME_BITS:0]   trial;
    logic                 q_bit;

    pdcm_seq u_seq (
        .clk   (clk),
        .rst_n (rst_n),
        .flags (flags),
        .ctrl  (ctrl),
        .step  (step)
    );

    assign edge_stall   = (step != S_IDLE);
    assign edge_take    = edge_valid && !edge_stall;
    assign out_free     = !out_vld_reg || !result_stall;
    assign result_valid = out_vld_reg;
    assign result_item  = out_reg;

    assign flags.no_item     = !edge_take;
    assign flags.rising      = rising_reg;
    assign flags.no_open     = !have_reg;
    assign flags.zero_period = (period_reg == '0);
    assign flags.high_ge     = (high_reg >= period_reg);
    assign flags.loop        = (cnt_reg != CNT_BITS'(1));
    assign flags.same        = (pct_reg == last_reg);
    assign flags.out_busy    = !out_free;

    // one restoring-divide step: bring down next dividend bit, try subtract
    assign trial = {rem_reg, dq_reg[DIV_BITS-1]};
    assign q_bit = (trial >= {1'b0, period_reg});

    always_comb
    begin
        rising_next  = rising_reg;
        now_next     = now_reg;
        edges_next   = edges_reg;
        rise_next    = rise_reg;
        ff_next      = ff_reg;
        have_next    = have_reg;
        last_next    = last_reg;
        period_next  = period_reg;
        high_next    = high_reg;
        prod_next    = prod_reg;
        rem_next     = rem_reg;
        dq_next      = dq_reg;
        cnt_next     = cnt_reg;
        pct_next     = pct_reg;
        out_next     = out_reg;
        out_vld_next = out_vld_reg && result_stall;

        case (ctrl.op)
            OP_NONE:
            begin
            end
            OP_LOAD:
            begin
                if (edge_take)
                begin
                    rising_next = edge_item.rising;
                    now_next    = TIME_BITS'(edge_item.capture_time);
                    edges_next  = edges_reg + 16'd1;
                end
            end
            OP_RISE:
            begin
                if (rising_reg)
                begin
                    rise_next = now_reg;
                end
            end
            OP_FALL:
            begin
                if (!have_reg)
                begin
                    ff_next   = now_reg;
                    have_next = 1'b1;
                end
                else
                begin
                    have_next   = 1'b0;
                    period_next = now_reg - ff_reg;
                    high_next   = now_reg - rise_reg;
                end
            end
            OP_MUL:
            begin
                prod_next = PROD_BITS'(high_reg) * PROD_BITS'(PCT_FULL);
            end
            OP_SAT:
            begin
                pct_next = PCT_FULL;
            end
            OP_DIV_INIT:
            begin
                // high < period here, so the top part is already below the divisor
                rem_next = prod_reg[PROD_BITS-1:DIV_BITS];
                dq_next  = prod_reg[DIV_BITS-1:0];
                cnt_next = CNT_BITS'(DIV_BITS);
            end
            OP_DIV_STEP:
            begin
                rem_next = q_bit ? TIME_BITS'(trial - {1'b0, period_reg})
                                 : trial[TIME_BITS-1:0];
                dq_next  = {dq_reg[DIV_BITS-2:0], q_bit};
                cnt_next = cnt_reg - CNT_BITS'(1);
            end
            OP_TAKE_Q:
            begin
                pct_next = PCT_BITS'(dq_reg);
            end
            OP_EMIT:
            begin
                if (out_free)
                begin
                    last_next            = pct_reg;
                    out_vld_next         = 1'b1;
                    out_next.duty_percent = pct_reg;
                    out_next.period_ticks = 16'(period_reg);
                    out_next.high_ticks   = 16'(high_reg);
                    out_next.edge_count   = edges_reg;
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            edges_reg   <= '0;
            rise_reg    <= '0;
            ff_reg      <= '0;
            have_reg    <= 1'b0;
            last_reg    <= '0;
            out_vld_reg <= 1'b0;
        end
        else
        begin
            edges_reg   <= edges_next;
            rise_reg    <= rise_next;
            ff_reg      <= ff_next;
            have_reg    <= have_next;
            last_reg    <= last_next;
            out_vld_reg <= out_vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rising_reg <= rising_next;
        now_reg    <= now_next;
        period_reg <= period_next;
        high_reg   <= high_next;
        prod_reg   <= prod_next;
        rem_reg    <= rem_next;
        dq_reg     <= dq_next;
        cnt_reg    <= cnt_next;
        pct_reg    <= pct_next;
        out_reg    <= out_next;
    end

endmodule

// ===== design/pdcm_checker.sv =====
// Port-level checker for the duty-cycle meter, bound to the top level.
module pdcm_checker
    import pdcm_pkg::*;
(
    input logic         clk,
    input logic         rst_n,
    input logic         edge_valid,
    input logic         edge_stall,
    input logic         result_valid,
    input logic         result_stall,
    input result_item_t result_item
);

    // duty never above full scale
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> (result_item.duty_percent <= PCT_FULL))
        else $error("duty above 100 percent");

    // a zero period never produces a result
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> (result_item.period_ticks != 16'd0))
        else $error("result with zero period");

    // high time at or beyond the period saturates
    assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && (result_item.high_ticks >= result_item.period_ticks))
            |-> (result_item.duty_percent == PCT_FULL))
        else $error("duty not saturated");

    // one edge at a time: busy right after taking one
    assert property (@(posedge clk) disable iff (!rst_n)
        (edge_valid && !edge_stall) |=> edge_stall)
        else $error("edge accepted while busy");

    // held result stays put
    assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && result_stall) |=> (result_valid && $stable(result_item)))
        else $error("stalled result changed");

endmodule

bind pwm_duty_cycle_meter_top pdcm_checker u_pdcm_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .edge_valid   (edge_valid),
    .edge_stall   (edge_stall),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result_item  (result_item)
);
